FILE: rtl/core/sprsel_pkg.sv
// Shared types and constants for the scanline sprite select and sort unit.
package sprsel_pkg;

   localparam int MAX_PER_LINE_DEFAULT = 10;
   localparam int CMD_QUEUE_DEPTH      = 4;

   typedef enum logic [0:0] {
      CSR_TALL_SPRITES    = 1'b0,
      CSR_SPRITES_ENABLED = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [7:0] line;
      logic [5:0] entry_index;
      logic [7:0] sprite_y;
      logic [7:0] sprite_x;
      logic [7:0] tile_number;
      logic [7:0] attribute_bits;
      logic       final_entry;
   } req_type;

   typedef struct packed {
      logic       valid_res;
      logic [5:0] out_index;
      logic [7:0] out_y;
      logic [7:0] out_x;
      logic [7:0] out_tile;
      logic [7:0] out_attributes;
      logic       last_of_list;
   } rsp_type;

   typedef struct packed {
      logic [5:0] index;
      logic [7:0] y;
      logic [7:0] x;
      logic [7:0] tile;
      logic [7:0] attr;
   } sprite_type;

   // Command from the front end to the back end.
   typedef struct packed {
      logic       insert;
      logic       flush;
      logic       enabled;
      sprite_type sprite;
   } cmd_type;

   // Sort key: x first, table index breaks ties.
   function automatic logic sorts_before(sprite_type a, sprite_type b);
      return (a.x < b.x) || ((a.x == b.x) && (a.index < b.index));
   endfunction

endpackage

FILE: rtl/core/sprsel_front.sv
// Front end: config registers, in-range test and chosen count per scan.
module sprsel_front
   import sprsel_pkg::*;
#(
   parameter int MAX_PER_LINE = MAX_PER_LINE_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  req_type       req_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic          csr_wdata,
   input  logic          cmd_full,
   output logic          cmd_push,
   output cmd_type       cmd_data
);

   localparam int CW = $clog2(MAX_PER_LINE + 1);

   logic          tall_ff, tall_in;
   logic          enable_ff, enable_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          accept;
   logic          choose;
   logic [8:0]    line16;
   logic [8:0]    y_end;

   assign csr_ready = 1'b1;
   assign req_full  = cmd_full;
   assign accept    = req_push && !cmd_full;

   assign line16 = {1'b0, req_data.line} + 9'd16;
   assign y_end  = {1'b0, req_data.sprite_y} + (tall_ff ? 9'd16 : 9'd8);

   assign choose = enable_ff && (cnt_ff < CW'(MAX_PER_LINE))
                && (req_data.sprite_x != 8'd0) && (req_data.sprite_y != 8'd0)
                && ({1'b0, req_data.sprite_y} <= line16) && (line16 < y_end);

   always_comb begin
      tall_in   = tall_ff;
      enable_in = enable_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_TALL_SPRITES:    tall_in   = csr_wdata;
            CSR_SPRITES_ENABLED: enable_in = csr_wdata;
            default: ;
         endcase
      end
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_data.final_entry) begin
            cnt_in = '0;
         end else if (choose) begin
            cnt_in = cnt_ff + CW'(1);
         end
      end
   end

   assign cmd_push            = accept && (choose || req_data.final_entry);
   assign cmd_data.insert     = choose;
   assign cmd_data.flush      = req_data.final_entry;
   assign cmd_data.enabled    = enable_ff;
   assign cmd_data.sprite.index = req_data.entry_index;
   assign cmd_data.sprite.y     = req_data.sprite_y;
   assign cmd_data.sprite.x     = req_data.sprite_x;
   assign cmd_data.sprite.tile  = req_data.tile_number;
   assign cmd_data.sprite.attr  = req_data.attribute_bits;

   always_ff @(posedge clock) begin
      if (reset) begin
         tall_ff   <= 1'b1;
         enable_ff <= 1'b1;
         cnt_ff    <= '0;
      end else begin
         tall_ff   <= tall_in;
         enable_ff <= enable_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: rtl/core/sprsel_cmd_fifo.sv
// Short command queue between the front and back ends.
module sprsel_cmd_fifo
   import sprsel_pkg::*;
#(
   parameter int DEPTH = CMD_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   cmd_type       slot_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] fill_ff, fill_in;
   logic          do_push, do_pop;

   assign full    = (fill_ff == CW'(DEPTH));
   assign empty   = (fill_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: rtl/core/sprsel_back.sv
// Back end: sorted sprite list with insertion, and the drain to the result register.
module sprsel_back
   import sprsel_pkg::*;
#(
   parameter int MAX_PER_LINE = MAX_PER_LINE_DEFAULT
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_empty,
   input  cmd_type cmd_head,
   output logic    cmd_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int CW = $clog2(MAX_PER_LINE + 1);

   typedef enum logic [1:0] {
      BK_IDLE = 2'b01,
      BK_EMIT = 2'b10
   } back_state_type;

   back_state_type state_ff, state_in;
   sprite_type     list_ff [MAX_PER_LINE];
   sprite_type     list_in [MAX_PER_LINE];
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic           en_ff, en_in;
   logic           out_valid_ff, out_valid_in;
   rsp_type        out_ff, out_in;
   logic           out_free;
   logic           out_load;
   logic [MAX_PER_LINE-1:0] shift;

   assign out_free  = !out_valid_ff || rsp_pop;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = out_ff;
   assign cmd_pop   = (state_ff == BK_IDLE) && !cmd_empty;
   assign out_load  = (state_ff == BK_EMIT) && out_free;

   // Entries that the new sprite goes in front of; a sorted list makes this a suffix.
   always_comb begin
      for (int k = 0; k < MAX_PER_LINE; k++) begin
         shift[k] = (CW'(k) < cnt_ff) && sorts_before(cmd_head.sprite, list_ff[k]);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      en_in        = en_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      out_in       = out_ff;
      for (int k = 0; k < MAX_PER_LINE; k++) begin
         list_in[k] = list_ff[k];
      end
      case (state_ff)
         BK_IDLE: begin
            if (cmd_pop) begin
               if (cmd_head.insert) begin
                  for (int k = 0; k < MAX_PER_LINE; k++) begin
                     if (k > 0 && shift[(k > 0) ? k - 1 : 0]) begin
                        list_in[k] = list_ff[(k > 0) ? k - 1 : 0];
                     end else if (shift[k] || CW'(k) == cnt_ff) begin
                        list_in[k] = cmd_head.sprite;
                     end
                  end
                  cnt_in = cnt_ff + CW'(1);
               end
               if (cmd_head.flush) begin
                  en_in    = cmd_head.enabled;
                  state_in = BK_EMIT;
               end
            end
         end
         BK_EMIT: begin
            if (out_load) begin
               out_valid_in = 1'b1;
               if (!en_ff || cnt_ff == '0) begin
                  out_in              = '0;
                  out_in.last_of_list = 1'b1;
                  cnt_in              = '0;
                  state_in            = BK_IDLE;
               end else begin
                  out_in.valid_res      = 1'b1;
                  out_in.out_index      = list_ff[0].index;
                  out_in.out_y          = list_ff[0].y;
                  out_in.out_x          = list_ff[0].x;
                  out_in.out_tile       = list_ff[0].tile;
                  out_in.out_attributes = list_ff[0].attr;
                  out_in.last_of_list   = (cnt_ff == CW'(1));
                  for (int k = 0; k < MAX_PER_LINE - 1; k++) begin
                     list_in[k] = list_ff[k + 1];
                  end
                  cnt_in = cnt_ff - CW'(1);
                  if (cnt_ff == CW'(1)) begin
                     state_in = BK_IDLE;
                  end
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         cnt_ff       <= '0;
         en_ff        <= 1'b1;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         en_ff        <= en_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
      for (int k = 0; k < MAX_PER_LINE; k++) begin
         list_ff[k] <= list_in[k];
      end
   end

`ifndef SYNTH
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_PER_LINE))
      else $error("sprite list count beyond capacity");

   a_no_insert_when_full: assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && cmd_head.insert) |-> (cnt_ff < CW'(MAX_PER_LINE)))
      else $error("insert into full sprite list");

   a_last_ends_drain: assert property (@(posedge clock) disable iff (reset)
      (out_load && out_in.last_of_list) |=> (state_ff == BK_IDLE) && (cnt_ff == '0))
      else $error("drain did not end on last beat");

   a_empty_item_is_last: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_ff.valid_res) |-> out_ff.last_of_list)
      else $error("empty-list beat not flagged last");
`endif

endmodule

FILE: rtl/core/scanline_sprite_select_sort_unit.sv
// Top level of the scanline sprite select and sort unit.
// Takes one attribute entry per beat; the front end tests it against the line and
// passes chosen entries through a 4-deep command queue to the back end, which
// insertion-sorts them (by x, then index) into a register list. Entries that are
// neither chosen nor final are not queued. On the final entry the back end
// drains the list at one result per cycle through an output register while the
// consumer keeps popping; an empty list gives a single empty-list beat flagged last;
// new entries keep being accepted while the queue has room. No clearing pass.
module scanline_sprite_select_sort_unit
   import sprsel_pkg::*;
#(
   parameter int MAX_PER_LINE = MAX_PER_LINE_DEFAULT
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  req_type       req_data,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_data,
   input  logic          csr_valid,
   output logic          csr_ready,
   input  csr_index_type csr_index,
   input  logic          csr_wdata
);

   logic    cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type cmd_push_data, cmd_head;

   sprsel_front #(
      .MAX_PER_LINE(MAX_PER_LINE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd_full  (cmd_full),
      .cmd_push  (cmd_push),
      .cmd_data  (cmd_push_data)
   );

   sprsel_cmd_fifo #(
      .DEPTH(CMD_QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_push_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   sprsel_back #(
      .MAX_PER_LINE(MAX_PER_LINE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_head  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
